@@ hw/rtl/bwc_pkg.sv @@
// shared types, register indexes and constants for the buoyancy wrench calculator
// no dependencies
package bwc_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_LINK_MASS    = 3'd0,
    REG_COMP_RATIO   = 3'd1,
    REG_EXTRA_FORCE  = 3'd2,
    REG_OFFSET_X     = 3'd3,
    REG_OFFSET_Y     = 3'd4,
    REG_OFFSET_Z     = 3'd5,
    REG_HEIGHT_LIMIT = 3'd6
  } reg_idx_t;

  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned NUM_W     = 52;   // dividend: (h - cz) * 2^16 + |h|
  localparam int unsigned DEN_W     = 33;   // divisor: 2 |h|
  localparam int unsigned Q_W       = 17;   // scale, Q16.16 in [0, 1.0]
  localparam int unsigned DIV_LAT   = Q_W + 1;
  localparam logic [Q_W-1:0] SCALE_ONE = 17'd65536;
  localparam logic [20:0] GRAVITY_Q16 = 21'd642908;  // 9.81 in Q16.16
  localparam logic signed [15:0] QUAT_MAX = 16'sd16384;
  localparam logic signed [15:0] QUAT_MIN = -16'sd16384;
  localparam logic signed [31:0] ONE_Q28  = 32'sd268435456;

  // signed saturation of a wide value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [69:0] x);
    logic signed [31:0] res;
    if ((x[69:31] == '0) || (x[69:31] == '1)) begin
      res = x[31:0];
    end else if (x[69]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7fff_ffff;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/bwc_div.sv @@
// pipelined restoring divider for the height scale, one quotient bit per stage
// depends on bwc_pkg
module bwc_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [bwc_pkg::NUM_W-1:0] num,
  input  logic [bwc_pkg::DEN_W-1:0] den,
  output logic [bwc_pkg::Q_W-1:0]   scale
);
  import bwc_pkg::*;

  logic [NUM_W-1:0] rem_r [0:Q_W];
  logic [DEN_W-1:0] den_r [0:Q_W];
  logic [Q_W-1:0]   q_r   [0:Q_W];
  logic             sat_r [0:Q_W];

  logic [NUM_W-1:0] rem_nxt [1:Q_W];
  logic             bit_nxt [1:Q_W];

  // stage k decides quotient bit Q_W-k
  always_comb begin
    for (int k = 1; k <= Q_W; k++) begin
      logic [NUM_W-1:0] sub;
      sub = NUM_W'({den_r[k-1]}) << (Q_W - k);
      bit_nxt[k] = (rem_r[k-1] >= sub);
      rem_nxt[k] = bit_nxt[k] ? rem_r[k-1] - sub : rem_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      sat_r[0] <= (num >= {2'b00, den, 17'b0});
      for (int k = 1; k <= Q_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_r[k-1];
        q_r[k]   <= q_r[k-1] | (Q_W'(bit_nxt[k]) << (Q_W - k));
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign scale = (sat_r[Q_W] || (q_r[Q_W] > SCALE_ONE)) ? SCALE_ONE : q_r[Q_W];

endmodule

@@ hw/rtl/buoyancy_wrench_calc_top.sv @@
// top level of the buoyancy wrench calculator: config registers and the pose pipeline
// depends on bwc_pkg and bwc_div
//
// One pose (position and Q2.14 quaternion) enters per clock and one result
// (force_z, torque_x, torque_y in Q16.16) leaves per clock while out_stall is
// low. The 17-bit height-scale divider resolves one quotient bit per stage
// after a range check stage. The whole pipeline advances together whenever the
// output register is empty or being taken, so in_stall is high only while a
// result waits on out_stall. Configuration (APB, 4-byte registers at 0x00..0x18,
// pready tied high) is to be written between bursts while the pipeline is empty;
// the block itself does not enforce this. pos_x and pos_y are not carried into
// the pipeline and do not affect the result.
module buoyancy_wrench_calc_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bwc_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bwc_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bwc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bwc_pkg::*;

  // ---------------- configuration registers ----------------
  logic        [30:0] link_mass_r;
  logic signed [31:0] comp_r, extra_r, off_x_r, off_y_r, off_z_r, height_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_mass_r <= 31'd65536;
      comp_r      <= 32'sd65536;
      extra_r     <= '0;
      off_x_r     <= '0;
      off_y_r     <= '0;
      off_z_r     <= '0;
      height_r    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_LINK_MASS:    link_mass_r <= pwdata[30:0];
        REG_COMP_RATIO:   comp_r      <= pwdata;
        REG_EXTRA_FORCE:  extra_r     <= pwdata;
        REG_OFFSET_X:     off_x_r     <= pwdata;
        REG_OFFSET_Y:     off_y_r     <= pwdata;
        REG_OFFSET_Z:     off_z_r     <= pwdata;
        REG_HEIGHT_LIMIT: height_r    <= pwdata;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_LINK_MASS:    prdata = {1'b0, link_mass_r};
      REG_COMP_RATIO:   prdata = comp_r;
      REG_EXTRA_FORCE:  prdata = extra_r;
      REG_OFFSET_X:     prdata = off_x_r;
      REG_OFFSET_Y:     prdata = off_y_r;
      REG_OFFSET_Z:     prdata = off_z_r;
      REG_HEIGHT_LIMIT: prdata = height_r;
      default:          prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // every stage moves at once; the output register is the only place a result waits
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign out_valid = out_valid_r;

  function automatic logic signed [15:0] clamp_q(input logic signed [15:0] v);
    logic signed [15:0] res;
    if (v > QUAT_MAX) begin
      res = QUAT_MAX;
    end else if (v < QUAT_MIN) begin
      res = QUAT_MIN;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // stage 1: clamp quaternion, mass times compensation
  logic               v1_r;
  logic signed [31:0] pz1_r;
  logic signed [15:0] qw1_r, qx1_r, qy1_r, qz1_r;
  logic signed [63:0] mprod1_r;

  // stage 2: rotation matrix in Q.28, rounded and clamped mc
  logic               v2_r;
  logic signed [31:0] pz2_r;
  logic signed [31:0] m2_r [0:8];
  logic signed [44:0] mc2_r;
  logic signed [31:0] m_nxt [0:8];
  logic signed [44:0] mc_nxt;

  always_comb begin
    logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [63:0] t;
    logic signed [47:0] s;
    xx = qx1_r * qx1_r;  yy = qy1_r * qy1_r;  zz = qz1_r * qz1_r;
    xy = qx1_r * qy1_r;  xz = qx1_r * qz1_r;  yz = qy1_r * qz1_r;
    wx = qw1_r * qx1_r;  wy = qw1_r * qy1_r;  wz = qw1_r * qz1_r;
    m_nxt[0] = ONE_Q28 - 2 * (yy + zz);
    m_nxt[1] = 2 * (xy - wz);
    m_nxt[2] = 2 * (xz + wy);
    m_nxt[3] = 2 * (xy + wz);
    m_nxt[4] = ONE_Q28 - 2 * (xx + zz);
    m_nxt[5] = 2 * (yz - wx);
    m_nxt[6] = 2 * (xz - wy);
    m_nxt[7] = 2 * (yz + wx);
    m_nxt[8] = ONE_Q28 - 2 * (xx + yy);
    t = mprod1_r + 64'sd32768;
    s = 48'(t >>> 16);
    if (s > 48'sd8796093022208) begin
      mc_nxt = 45'sd8796093022208;
    end else if (s < -48'sd8796093022208) begin
      mc_nxt = -45'sd8796093022208;
    end else begin
      mc_nxt = 45'(s);
    end
  end

  // stage 3: matrix times offset, weight product
  logic               v3_r;
  logic signed [31:0] pz3_r;
  logic signed [63:0] p3_r [0:8];
  logic signed [65:0] wprod3_r;

  // stage 4: rotated offset rounded to Q16.16, base force f0
  logic               v4_r;
  logic signed [31:0] pz4_r, rx4_r, ry4_r, rz4_r;
  logic signed [50:0] f04_r;
  logic signed [31:0] rx_nxt, ry_nxt, rz_nxt;
  logic signed [50:0] f0_nxt;

  always_comb begin
    logic signed [65:0] sx, sy, sz, wt;
    sx = 66'(p3_r[0]) + 66'(p3_r[1]) + 66'(p3_r[2]) + 66'sd134217728;
    sy = 66'(p3_r[3]) + 66'(p3_r[4]) + 66'(p3_r[5]) + 66'sd134217728;
    sz = 66'(p3_r[6]) + 66'(p3_r[7]) + 66'(p3_r[8]) + 66'sd134217728;
    rx_nxt = sat32(70'(sx >>> 28));
    ry_nxt = sat32(70'(sy >>> 28));
    rz_nxt = sat32(70'(sz >>> 28));
    wt     = (wprod3_r + 66'sd32768) >>> 16;
    f0_nxt = 51'(wt) + 51'(extra_r);
  end

  // stage 5: centre height, scale case and divider operands
  logic               v5_r;
  logic               above5_r, hzero5_r;
  logic signed [31:0] rx5_r, ry5_r;
  logic signed [50:0] f05_r;
  logic [NUM_W-1:0]   num5_r;
  logic [DEN_W-1:0]   den5_r;
  logic               above_nxt;
  logic [NUM_W-1:0]   num_nxt;
  logic [DEN_W-1:0]   den_nxt;

  always_comb begin
    logic signed [33:0] cz;
    logic signed [34:0] dlt;
    logic [31:0]        habs;
    cz   = 34'(pz4_r) + 34'(rz4_r);
    dlt  = 35'(height_r) - 35'(cz);
    habs = height_r[31] ? 32'(-33'(height_r)) : height_r;
    above_nxt = (35'(cz) > 35'(height_r));
    num_nxt = (NUM_W'(dlt[33:0]) << 16) + NUM_W'(habs);
    den_nxt = {habs, 1'b0};
  end

  // divider stages, side data delayed to match
  logic [Q_W-1:0]     div_scale;
  logic               vd_r     [0:DIV_LAT-1];
  logic               aboved_r [0:DIV_LAT-1];
  logic               hzerod_r [0:DIV_LAT-1];
  logic signed [31:0] rxd_r    [0:DIV_LAT-1];
  logic signed [31:0] ryd_r    [0:DIV_LAT-1];
  logic signed [50:0] f0d_r    [0:DIV_LAT-1];

  bwc_div u_div (
    .clk   (clk),
    .en    (adv),
    .num   (num5_r),
    .den   (den5_r),
    .scale (div_scale)
  );

  // stage F: force before rounding
  logic               vf_r;
  logic signed [31:0] rxf_r, ryf_r;
  logic signed [68:0] fprod_r;
  logic [Q_W-1:0]     scale_nxt;

  always_comb begin
    if (aboved_r[DIV_LAT-1]) begin
      scale_nxt = '0;
    end else if (hzerod_r[DIV_LAT-1]) begin
      scale_nxt = SCALE_ONE;
    end else begin
      scale_nxt = div_scale;
    end
  end

  // stage G: rounded, saturated force
  logic               vg_r;
  logic signed [31:0] rxg_r, ryg_r, forceg_r;

  // stage H: torque products
  logic               vh_r;
  logic signed [31:0] forceh_r;
  logic signed [64:0] txp_r, typ_r;

  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;  v2_r <= 1'b0;  v3_r <= 1'b0;  v4_r <= 1'b0;  v5_r <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) begin
        vd_r[k] <= 1'b0;
      end
      vf_r <= 1'b0;  vg_r <= 1'b0;  vh_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      vd_r[0] <= v5_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
      vf_r <= vd_r[DIV_LAT-1];
      vg_r <= vf_r;
      vh_r <= vg_r;
      out_valid_r <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pz1_r    <= in_data.pos_z;
      qw1_r    <= clamp_q(in_data.quat_w);
      qx1_r    <= clamp_q(in_data.quat_x);
      qy1_r    <= clamp_q(in_data.quat_y);
      qz1_r    <= clamp_q(in_data.quat_z);
      mprod1_r <= 64'(signed'({1'b0, link_mass_r})) * 64'(comp_r);

      pz2_r <= pz1_r;
      for (int k = 0; k < 9; k++) begin
        m2_r[k] <= m_nxt[k];
      end
      mc2_r <= mc_nxt;

      pz3_r <= pz2_r;
      p3_r[0] <= 64'(m2_r[0]) * 64'(off_x_r);
      p3_r[1] <= 64'(m2_r[1]) * 64'(off_y_r);
      p3_r[2] <= 64'(m2_r[2]) * 64'(off_z_r);
      p3_r[3] <= 64'(m2_r[3]) * 64'(off_x_r);
      p3_r[4] <= 64'(m2_r[4]) * 64'(off_y_r);
      p3_r[5] <= 64'(m2_r[5]) * 64'(off_z_r);
      p3_r[6] <= 64'(m2_r[6]) * 64'(off_x_r);
      p3_r[7] <= 64'(m2_r[7]) * 64'(off_y_r);
      p3_r[8] <= 64'(m2_r[8]) * 64'(off_z_r);
      wprod3_r <= 66'(mc2_r) * 66'(signed'(GRAVITY_Q16));

      pz4_r <= pz3_r;
      rx4_r <= rx_nxt;
      ry4_r <= ry_nxt;
      rz4_r <= rz_nxt;
      f04_r <= f0_nxt;

      above5_r <= above_nxt;
      hzero5_r <= (height_r == '0);
      rx5_r    <= rx4_r;
      ry5_r    <= ry4_r;
      f05_r    <= f04_r;
      num5_r   <= num_nxt;
      den5_r   <= den_nxt;

      aboved_r[0] <= above5_r;
      hzerod_r[0] <= hzero5_r;
      rxd_r[0]    <= rx5_r;
      ryd_r[0]    <= ry5_r;
      f0d_r[0]    <= f05_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        aboved_r[k] <= aboved_r[k-1];
        hzerod_r[k] <= hzerod_r[k-1];
        rxd_r[k]    <= rxd_r[k-1];
        ryd_r[k]    <= ryd_r[k-1];
        f0d_r[k]    <= f0d_r[k-1];
      end

      rxf_r   <= rxd_r[DIV_LAT-1];
      ryf_r   <= ryd_r[DIV_LAT-1];
      fprod_r <= 69'(f0d_r[DIV_LAT-1]) * 69'(signed'({1'b0, scale_nxt}));

      rxg_r    <= rxf_r;
      ryg_r    <= ryf_r;
      forceg_r <= sat32(70'((fprod_r + 69'sd32768) >>> 16));

      forceh_r <= forceg_r;
      txp_r    <= -(65'(forceg_r) * 65'(ryg_r));
      typ_r    <= 65'(forceg_r) * 65'(rxg_r);

      out_r.force_z  <= forceh_r;
      out_r.torque_x <= sat32(70'((txp_r + 65'sd32768) >>> 16));
      out_r.torque_y <= sat32(70'((typ_r + 65'sd32768) >>> 16));
    end
  end

  assign out_data = out_r;

endmodule

@@ hw/rtl/bwc_check.sv @@
// port-level checks for the buoyancy wrench calculator, bound to the top level
// depends on bwc_pkg and buoyancy_wrench_calc_top
module bwc_check (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input bwc_pkg::out_item_t         out_data
);
  import bwc_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // zero force gives zero torque
  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.force_z == '0) |->
      (out_data.torque_x == '0) && (out_data.torque_y == '0))
    else $error("torque without force");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind buoyancy_wrench_calc_top bwc_check u_bwc_check (.*);
